// ===== design/row_layout_spacer_defines.svh =====
// Assertion macros for the row layout spacer.
// No dependencies; included by the top level only.
`ifndef ROW_LAYOUT_SPACER_DEFINES_SVH
`define ROW_LAYOUT_SPACER_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset
`define RLS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition implies another in the same cycle
`define RLS_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`else

`define RLS_ASSERT(lbl, prop, msg)
`define RLS_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ===== design/rls_pkg.sv =====
// Shared constants, types and register codes for the row layout spacer.
// No dependencies; imported by the channel interfaces, divider, datapath, controller and top level.
package rls_pkg;

   // Capacity and field widths
   localparam int MAX_ITEMS = 16;
   localparam int DIM_W     = 12;
   localparam int POS_W     = 16;
   localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int SUM_W     = DIM_W + IDX_W;
   localparam int REM_W     = SUM_W + 1;
   localparam int STEP_W    = $clog2(SUM_W + 1);

   // Register port
   localparam int NUM_REGS  = 4;
   localparam int PADDR_W   = $clog2(NUM_REGS) + 2;
   localparam int PDATA_W   = 32;

   typedef enum logic [$clog2(NUM_REGS)-1:0] {
      CSR_AREA_X,
      CSR_AREA_Y,
      CSR_AREA_WIDTH,
      CSR_AREA_HEIGHT
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] area_x;
      logic signed [POS_W-1:0] area_y;
      logic [DIM_W-1:0]        area_width;
      logic [DIM_W-1:0]        area_height;
   } cfg_type;

   typedef struct packed {
      logic collect;
      logic start;
      logic step;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic row_done;
      logic div_done;
      logic out_free;
      logic last_item;
   } ctrl_status_type;

endpackage

// ===== design/rls_req_if.sv =====
// Request channel: one rectangle of the row per transfer.
// Depends on rls_pkg for field widths.
interface rls_req_if
   import rls_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [DIM_W-1:0] item_width;
   logic [DIM_W-1:0] item_height;
   logic             row_end;

   modport source (output valid, item_width, item_height, row_end, input ready);
   modport sink (input valid, item_width, item_height, row_end, output ready);
endinterface

// ===== design/rls_rsp_if.sv =====
// Response channel: one placed rectangle per transfer.
// Depends on rls_pkg for field widths.
interface rls_rsp_if
   import rls_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] place_x;
   logic signed [POS_W-1:0] place_y;
   logic [DIM_W-1:0]        place_width;
   logic [DIM_W-1:0]        place_height;
   logic                    last_of_row;
   logic                    width_error;

   modport source (output valid, place_x, place_y, place_width, place_height,
                   last_of_row, width_error, input ready);
   modport sink (input valid, place_x, place_y, place_width, place_height,
                 last_of_row, width_error, output ready);
endinterface

// ===== design/rls_ram.sv =====
// Generic single-port-write, registered-read RAM.
// No dependencies.
module rls_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/rls_divider.sv =====
// Bit-serial signed divider, truncating toward zero, one quotient bit a cycle while step is high.
// Depends on rls_pkg for widths.
module rls_divider
   import rls_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    step,
   input  logic signed [REM_W-1:0] dividend,
   input  logic [IDX_W-1:0]        divisor,
   output logic                    done,
   output logic signed [REM_W-1:0] quotient
);
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic [IDX_W-1:0]  div_ff, div_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0]  mag;
   logic [IDX_W:0]    trial;
   logic              fit;

   // Magnitude of the dividend and the trial subtraction
   assign mag   = dividend[REM_W-1] ? REM_W'(-dividend) : REM_W'(dividend);
   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign fit   = (trial >= {1'b0, div_ff});

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = mag[SUM_W-1:0];
         rem_in = '0;
         div_in = divisor;
         neg_in = dividend[REM_W-1];
         cnt_in = STEP_W'(SUM_W);
      end else if (step && (cnt_ff != '0)) begin
         // Shift in one dividend bit, subtract when it fits
         rem_in = fit ? IDX_W'(trial - {1'b0, div_ff}) : trial[IDX_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fit};
         cnt_in = cnt_ff - STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done     = (cnt_ff == '0);
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
endmodule

// ===== design/rls_datapath.sv =====
// Datapath: item store, running width sum, gap division and placement.
// Depends on rls_pkg, rls_req_if, rls_rsp_if, rls_ram and rls_divider.
module rls_datapath
   import rls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   rls_req_if.sink         req,
   rls_rsp_if.source       rsp
);
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic                    dropped_ff, dropped_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic signed [POS_W-1:0] x_ff, x_in;
   logic signed [REM_W-1:0] remain_ff, remain_in;
   logic                    gz_ff, gz_in;

   logic                    valid_ff, valid_in;
   logic signed [POS_W-1:0] px_ff, py_ff;
   logic [DIM_W-1:0]        pw_ff, ph_ff;
   logic                    plast_ff, perr_ff;

   logic                    take, store, clear;
   logic [2*DIM_W-1:0]      rd_data;
   logic [DIM_W-1:0]        iw, ih;
   logic [CNT_W-1:0]        gaps_w;
   logic                    div_done;
   logic signed [REM_W-1:0] quotient, q_eff;
   logic [REM_W-1:0]        aw_ext, sum_ext;
   logic signed [DIM_W:0]   hdiff, hhalf;
   logic signed [POS_W-1:0] py;
   logic                    fits, err;

   // Request side
   assign req.ready = cmd.collect;
   assign take      = req.valid && req.ready;
   assign store     = take && (count_ff < CNT_W'(MAX_ITEMS));
   assign clear     = cmd.emit && status.last_item;

   rls_ram #(
      .WIDTH (2 * DIM_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data ({req.item_width, req.item_height}),
      .rd_en   (cmd.start),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign iw = rd_data[2*DIM_W-1:DIM_W];
   assign ih = rd_data[DIM_W-1:0];

   // Gaps still to come after the current item
   assign gaps_w = count_ff - CNT_W'(1) - CNT_W'(idx_ff);

   rls_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start),
      .step     (cmd.step),
      .dividend (remain_ff),
      .divisor  (gaps_w[IDX_W-1:0]),
      .done     (div_done),
      .quotient (quotient)
   );

   assign q_eff = gz_ff ? '0 : quotient;

   // Vertical centering with a floor shift
   assign hdiff = $signed({1'b0, cfg.area_height}) - $signed({1'b0, ih});
   assign hhalf = hdiff >>> 1;
   assign py    = cfg.area_y + POS_W'(hhalf);

   // Fit check and error flag
   assign fits = (count_ff == CNT_W'(1)) ? (sum_ff <= SUM_W'(cfg.area_width))
                                         : (sum_ff < SUM_W'(cfg.area_width));
   assign err  = dropped_ff || !fits;

   assign aw_ext = REM_W'(cfg.area_width);
   assign sum_ext = REM_W'(sum_ff) + (store ? REM_W'(req.item_width) : REM_W'(0));

   always_comb begin
      count_in   = count_ff;
      sum_in     = sum_ff;
      dropped_in = dropped_ff;
      idx_in     = idx_ff;
      x_in       = x_ff;
      remain_in  = remain_ff;
      gz_in      = gz_ff;
      valid_in   = valid_ff;

      // Collect items, drop beyond capacity
      if (store) begin
         count_in = count_ff + CNT_W'(1);
         sum_in   = sum_ff + SUM_W'(req.item_width);
      end else if (take) begin
         dropped_in = 1'b1;
      end

      // Start a row: origin and slack
      if (take && req.row_end) begin
         idx_in    = '0;
         x_in      = cfg.area_x;
         remain_in = $signed(aw_ext - sum_ext);
      end

      if (cmd.start) begin
         gz_in = (gaps_w == '0);
      end

      // Drop the output once taken
      if (rsp.ready) begin
         valid_in = 1'b0;
      end

      // Advance position and slack past the emitted item
      if (cmd.emit) begin
         valid_in  = 1'b1;
         x_in      = x_ff + POS_W'(iw) + POS_W'(q_eff);
         remain_in = remain_ff - q_eff;
         idx_in    = idx_ff + IDX_W'(1);
      end

      if (clear) begin
         count_in   = '0;
         sum_in     = '0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sum_ff     <= '0;
         dropped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         sum_ff     <= sum_in;
         dropped_ff <= dropped_in;
         valid_ff   <= valid_in;
      end
      idx_ff    <= idx_in;
      x_ff      <= x_in;
      remain_ff <= remain_in;
      gz_ff     <= gz_in;
      if (cmd.emit) begin
         px_ff    <= x_ff;
         py_ff    <= py;
         pw_ff    <= iw;
         ph_ff    <= ih;
         plast_ff <= status.last_item;
         perr_ff  <= err;
      end
   end

   // Response side
   assign rsp.valid        = valid_ff;
   assign rsp.place_x      = px_ff;
   assign rsp.place_y      = py_ff;
   assign rsp.place_width  = pw_ff;
   assign rsp.place_height = ph_ff;
   assign rsp.last_of_row  = plast_ff;
   assign rsp.width_error  = perr_ff;

   // Status to the controller
   assign status.row_done  = take && req.row_end;
   assign status.div_done  = div_done;
   assign status.out_free  = !valid_ff || rsp.ready;
   assign status.last_item = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
endmodule

// ===== design/rls_ctrl.sv =====
// Controller: sequences collection, per-item read, division and emit.
// Depends on rls_pkg for command and status types.
module rls_ctrl
   import rls_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);
   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_READ,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // Advance through the row
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
      end else begin
         unique case (state_ff)
            ST_COLLECT: begin
               if (status.row_done) begin
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (status.div_done) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (status.out_free) begin
                  state_ff <= status.last_item ? ST_COLLECT : ST_READ;
               end
            end
            default: begin
               state_ff <= ST_COLLECT;
            end
         endcase
      end
   end

   // Commands from state
   always_comb begin
      cmd.collect = (state_ff == ST_COLLECT);
      cmd.start   = (state_ff == ST_READ);
      cmd.step    = (state_ff == ST_DIV);
      cmd.emit    = (state_ff == ST_EMIT) && status.out_free;
   end
endmodule

// ===== design/row_layout_spacer.sv =====
// Row layout spacer top level: register port, controller and datapath.
// Depends on rls_pkg, the channel interfaces, rls_ctrl and rls_datapath.
// A request without row end is taken while the controller collects; after a row end
// request is taken, each item passes in turn through the read, divide and emit states,
// paced by the bit-serial gap divider, and an emit waits while the output is stalled.
// Reset is synchronous, active high; it clears counts, flags and the config.
`include "row_layout_spacer_defines.svh"

module row_layout_spacer
   import rls_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   rls_req_if.sink            req_ch,
   rls_rsp_if.source          rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);
   cfg_type         cfg_ff;
   ctrl_cmd_type    ctrl_cmd;
   ctrl_status_type ctrl_status;
   csr_index_type   csr_index;
   logic            csr_write;

   // Register port
   assign pready    = 1'b1;
   assign csr_index = csr_index_type'(paddr[PADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_AREA_X:      cfg_ff.area_x      <= pwdata[POS_W-1:0];
            CSR_AREA_Y:      cfg_ff.area_y      <= pwdata[POS_W-1:0];
            CSR_AREA_WIDTH:  cfg_ff.area_width  <= pwdata[DIM_W-1:0];
            CSR_AREA_HEIGHT: cfg_ff.area_height <= pwdata[DIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_AREA_X:      prdata = PDATA_W'(cfg_ff.area_x);
         CSR_AREA_Y:      prdata = PDATA_W'(cfg_ff.area_y);
         CSR_AREA_WIDTH:  prdata = PDATA_W'(cfg_ff.area_width);
         CSR_AREA_HEIGHT: prdata = PDATA_W'(cfg_ff.area_height);
         default:         prdata = '0;
      endcase
   end

   rls_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (ctrl_status),
      .cmd    (ctrl_cmd)
   );

   rls_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .cmd    (ctrl_cmd),
      .status (ctrl_status),
      .req    (req_ch),
      .rsp    (rsp_ch)
   );

   // A row end request stops intake while the row is laid out
   `RLS_ASSERT(a_row_end_stops_intake, (req_ch.valid && req_ch.ready && req_ch.row_end) |=> !req_ch.ready, "request taken after row end")
   // A result is loaded only when the output register can take it
   `RLS_ASSERT_IMPLY(a_emit_into_free_slot, ctrl_cmd.emit, ctrl_status.out_free, "result overwrote pending response")
   // At most one controller command at a time
   `RLS_ASSERT(a_single_command, $onehot0({ctrl_cmd.collect, ctrl_cmd.start, ctrl_cmd.step, ctrl_cmd.emit}), "overlapping controller commands")
endmodule
